FILE: hdl/qrtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrtp_pkg: shared types and constants for the quaternion point transform
// Coordinate and quaternion formats, derived datapath widths, register
// indexes and the request, result and coefficient structures.
// ----------------------------------------------------------------------------
package qrtp_pkg;

    localparam int COORD_WIDTH     = 24;
    localparam int QUAT_FRAC_BITS  = 14;
    localparam int QUAT_WIDTH      = QUAT_FRAC_BITS + 2;

    // Exact quaternion products, matrix sums and rounded matrix entries.
    localparam int QPROD_WIDTH     = 2 * QUAT_WIDTH;
    localparam int QSUM_WIDTH      = QPROD_WIDTH + 2;
    localparam int ENTRY_WIDTH     = QSUM_WIDTH - QUAT_FRAC_BITS;

    // Entry times coordinate, and the sum of three of them plus offset.
    localparam int TERM_WIDTH      = ENTRY_WIDTH + COORD_WIDTH;
    localparam int ACC_WIDTH       = TERM_WIDTH + 2;

    localparam int CFG_WIDTH       = (COORD_WIDTH > QUAT_WIDTH) ? COORD_WIDTH : QUAT_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_QUAT_W   = 3'd0,
        REG_QUAT_X   = 3'd1,
        REG_QUAT_Y   = 3'd2,
        REG_QUAT_Z   = 3'd3,
        REG_OFFSET_X = 3'd4,
        REG_OFFSET_Y = 3'd5,
        REG_OFFSET_Z = 3'd6
    } cfg_reg_t;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [QUAT_WIDTH-1:0]  quat_t;
    typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        logic   last_point;
    } point_t;

    typedef struct packed {
        coord_t out_x;
        coord_t out_y;
        coord_t out_z;
        logic   out_last;
    } result_t;

    // Rotation matrix in row-major order and the translation offset.
    typedef struct packed {
        entry_t [8:0] m;
        coord_t [2:0] offset;
    } coef_t;

endpackage
`default_nettype wire

FILE: hdl/qrtp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrtp_front: configuration, matrix derivation and request intake
// Holds the quaternion and offset registers, derives the rotation matrix
// in two register stages and buffers each incoming request for the queue.
// ----------------------------------------------------------------------------
module qrtp_front (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [qrtp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [qrtp_pkg::CFG_WIDTH-1:0]         cfg_data,
    input  wire logic                                   point_valid,
    output logic                                        point_ready,
    input  wire qrtp_pkg::point_t                       point,
    output logic                                        push_valid,
    input  wire logic                                   push_ready,
    output qrtp_pkg::point_t                            push_data,
    output qrtp_pkg::coef_t                             coef
);

    localparam logic signed [qrtp_pkg::QSUM_WIDTH-1:0] ENTRY_HALF =
        qrtp_pkg::QSUM_WIDTH'(1) <<< (qrtp_pkg::QUAT_FRAC_BITS - 1);
    localparam logic signed [qrtp_pkg::QUAT_WIDTH-1:0] QUAT_ONE =
        qrtp_pkg::QUAT_WIDTH'(1) <<< qrtp_pkg::QUAT_FRAC_BITS;

    qrtp_pkg::quat_t  quat_w_reg, quat_x_reg, quat_y_reg, quat_z_reg;
    qrtp_pkg::coord_t offset_x_reg, offset_y_reg, offset_z_reg;

    logic signed [qrtp_pkg::QPROD_WIDTH-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [qrtp_pkg::QPROD_WIDTH-1:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;

    logic signed [qrtp_pkg::QSUM_WIDTH-1:0] sum_next [9];
    qrtp_pkg::entry_t [8:0] entry_reg;

    logic              hold_valid_reg;
    logic              hold_valid_next;
    qrtp_pkg::point_t  hold_data_reg;

    // Rounds an exact entry to QUAT_FRAC_BITS fraction bits, ties upward.
    function automatic qrtp_pkg::entry_t round_entry(
        input logic signed [qrtp_pkg::QSUM_WIDTH-1:0] v
    );
        logic signed [qrtp_pkg::QSUM_WIDTH-1:0] r;
        r = v + ENTRY_HALF;
        return r[qrtp_pkg::QSUM_WIDTH-1:qrtp_pkg::QUAT_FRAC_BITS];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_w_reg   <= QUAT_ONE;
            quat_x_reg   <= '0;
            quat_y_reg   <= '0;
            quat_z_reg   <= '0;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (qrtp_pkg::cfg_reg_t'(cfg_index))
                qrtp_pkg::REG_QUAT_W:   quat_w_reg   <= cfg_data[qrtp_pkg::QUAT_WIDTH-1:0];
                qrtp_pkg::REG_QUAT_X:   quat_x_reg   <= cfg_data[qrtp_pkg::QUAT_WIDTH-1:0];
                qrtp_pkg::REG_QUAT_Y:   quat_y_reg   <= cfg_data[qrtp_pkg::QUAT_WIDTH-1:0];
                qrtp_pkg::REG_QUAT_Z:   quat_z_reg   <= cfg_data[qrtp_pkg::QUAT_WIDTH-1:0];
                qrtp_pkg::REG_OFFSET_X: offset_x_reg <= cfg_data[qrtp_pkg::COORD_WIDTH-1:0];
                qrtp_pkg::REG_OFFSET_Y: offset_y_reg <= cfg_data[qrtp_pkg::COORD_WIDTH-1:0];
                qrtp_pkg::REG_OFFSET_Z: offset_z_reg <= cfg_data[qrtp_pkg::COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // The matrix follows the registers continuously; a request passes the
    // holding register and the queue before it reaches the back end, so one
    // accepted after a configuration write sees a settled matrix.
    always_ff @(posedge clk)
    begin
        ww_reg <= quat_w_reg * quat_w_reg;
        xx_reg <= quat_x_reg * quat_x_reg;
        yy_reg <= quat_y_reg * quat_y_reg;
        zz_reg <= quat_z_reg * quat_z_reg;
        xy_reg <= quat_x_reg * quat_y_reg;
        wz_reg <= quat_w_reg * quat_z_reg;
        xz_reg <= quat_x_reg * quat_z_reg;
        wy_reg <= quat_w_reg * quat_y_reg;
        yz_reg <= quat_y_reg * quat_z_reg;
        wx_reg <= quat_w_reg * quat_x_reg;
    end

    always_comb
    begin
        sum_next[0] = qrtp_pkg::QSUM_WIDTH'(ww_reg) + qrtp_pkg::QSUM_WIDTH'(xx_reg)
                    - qrtp_pkg::QSUM_WIDTH'(yy_reg) - qrtp_pkg::QSUM_WIDTH'(zz_reg);
        sum_next[1] = (qrtp_pkg::QSUM_WIDTH'(xy_reg) - qrtp_pkg::QSUM_WIDTH'(wz_reg)) <<< 1;
        sum_next[2] = (qrtp_pkg::QSUM_WIDTH'(xz_reg) + qrtp_pkg::QSUM_WIDTH'(wy_reg)) <<< 1;
        sum_next[3] = (qrtp_pkg::QSUM_WIDTH'(xy_reg) + qrtp_pkg::QSUM_WIDTH'(wz_reg)) <<< 1;
        sum_next[4] = qrtp_pkg::QSUM_WIDTH'(ww_reg) - qrtp_pkg::QSUM_WIDTH'(xx_reg)
                    + qrtp_pkg::QSUM_WIDTH'(yy_reg) - qrtp_pkg::QSUM_WIDTH'(zz_reg);
        sum_next[5] = (qrtp_pkg::QSUM_WIDTH'(yz_reg) - qrtp_pkg::QSUM_WIDTH'(wx_reg)) <<< 1;
        sum_next[6] = (qrtp_pkg::QSUM_WIDTH'(xz_reg) - qrtp_pkg::QSUM_WIDTH'(wy_reg)) <<< 1;
        sum_next[7] = (qrtp_pkg::QSUM_WIDTH'(yz_reg) + qrtp_pkg::QSUM_WIDTH'(wx_reg)) <<< 1;
        sum_next[8] = qrtp_pkg::QSUM_WIDTH'(ww_reg) - qrtp_pkg::QSUM_WIDTH'(xx_reg)
                    - qrtp_pkg::QSUM_WIDTH'(yy_reg) + qrtp_pkg::QSUM_WIDTH'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 9; i++)
        begin
            entry_reg[i] <= round_entry(sum_next[i]);
        end
    end

    assign coef.m         = entry_reg;
    assign coef.offset[0] = offset_x_reg;
    assign coef.offset[1] = offset_y_reg;
    assign coef.offset[2] = offset_z_reg;

    // Single holding register in front of the queue.
    assign point_ready = !hold_valid_reg || push_ready;
    assign push_valid  = hold_valid_reg;
    assign push_data   = hold_data_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (point_valid && point_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (point_valid && point_ready)
        begin
            hold_data_reg <= point;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/qrtp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrtp_queue: request queue between front and back end
// A small first-in first-out buffer that lets either side stall alone.
// ----------------------------------------------------------------------------
module qrtp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire qrtp_pkg::point_t  push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output qrtp_pkg::point_t       pop_data
);

    localparam int PTR_WIDTH = $clog2(qrtp_pkg::QUEUE_DEPTH);

    qrtp_pkg::point_t       store [qrtp_pkg::QUEUE_DEPTH];
    logic [PTR_WIDTH-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_WIDTH:0]     count_reg, count_next;
    logic                   push_fire, pop_fire;

    assign push_ready = (count_reg != (PTR_WIDTH + 1)'(qrtp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/qrtp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrtp_back: matrix-vector multiply, offset add, rounding and saturation
// Three stages: nine products, row sums with offset, then round and clamp
// into the result register. Each stage advances on its own.
// ----------------------------------------------------------------------------
module qrtp_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qrtp_pkg::coef_t   coef,
    input  wire logic              pop_valid,
    output logic                   pop_ready,
    input  wire qrtp_pkg::point_t  pop_data,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output qrtp_pkg::result_t      result
);

    localparam int SHIFT_WIDTH = qrtp_pkg::ACC_WIDTH - qrtp_pkg::QUAT_FRAC_BITS;
    localparam logic signed [qrtp_pkg::ACC_WIDTH-1:0] ACC_HALF =
        qrtp_pkg::ACC_WIDTH'(1) <<< (qrtp_pkg::QUAT_FRAC_BITS - 1);
    localparam logic signed [qrtp_pkg::COORD_WIDTH-1:0] COORD_MAX =
        {1'b0, {(qrtp_pkg::COORD_WIDTH - 1){1'b1}}};
    localparam logic signed [qrtp_pkg::COORD_WIDTH-1:0] COORD_MIN =
        {1'b1, {(qrtp_pkg::COORD_WIDTH - 1){1'b0}}};

    logic s1_valid_reg, s2_valid_reg, res_valid_reg;
    logic s1_adv, s2_adv, res_adv;

    logic signed [qrtp_pkg::TERM_WIDTH-1:0] term_reg [9];
    logic                                   s1_last_reg;
    logic signed [qrtp_pkg::ACC_WIDTH-1:0]  acc_reg [3];
    logic                                   s2_last_reg;
    qrtp_pkg::coord_t                       coord_next [3];
    qrtp_pkg::result_t                      result_reg;
    qrtp_pkg::coord_t                       pt [3];

    // Converts a row sum to the coordinate format with clamping.
    function automatic qrtp_pkg::coord_t round_sat(
        input logic signed [qrtp_pkg::ACC_WIDTH-1:0] a
    );
        logic [SHIFT_WIDTH-1:0]                      shifted;
        logic [SHIFT_WIDTH-qrtp_pkg::COORD_WIDTH:0]  upper;
        shifted = a[qrtp_pkg::ACC_WIDTH-1:qrtp_pkg::QUAT_FRAC_BITS];
        upper   = shifted[SHIFT_WIDTH-1:qrtp_pkg::COORD_WIDTH-1];
        if ((&upper) || !(|upper))
        begin
            return shifted[qrtp_pkg::COORD_WIDTH-1:0];
        end
        return shifted[SHIFT_WIDTH-1] ? COORD_MIN : COORD_MAX;
    endfunction

    assign res_adv   = !res_valid_reg || result_ready;
    assign s2_adv    = !s2_valid_reg || res_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign pop_ready = s1_adv;

    assign pt[0] = pop_data.point_x;
    assign pt[1] = pop_data.point_y;
    assign pt[2] = pop_data.point_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= pop_valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (res_adv)
            begin
                res_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && pop_valid)
        begin
            for (int i = 0; i < 9; i++)
            begin
                term_reg[i] <= coef.m[i] * pt[i % 3];
            end
            s1_last_reg <= pop_data.last_point;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv && s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc_reg[r] <= (qrtp_pkg::ACC_WIDTH'(coef.offset[r]) <<< qrtp_pkg::QUAT_FRAC_BITS)
                            + qrtp_pkg::ACC_WIDTH'(term_reg[3 * r])
                            + qrtp_pkg::ACC_WIDTH'(term_reg[3 * r + 1])
                            + qrtp_pkg::ACC_WIDTH'(term_reg[3 * r + 2])
                            + ACC_HALF;
            end
            s2_last_reg <= s1_last_reg;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            coord_next[r] = round_sat(acc_reg[r]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_adv && s2_valid_reg)
        begin
            result_reg.out_x    <= coord_next[0];
            result_reg.out_y    <= coord_next[1];
            result_reg.out_z    <= coord_next[2];
            result_reg.out_last <= s2_last_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

FILE: hdl/quaternion_rotate_translate_points_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_rotate_translate_points_core: rotate and translate 3-D points
// Rotates each point by the configured unit quaternion, adds the offset
// and saturates the result to the coordinate range.
//
//   Channel   Handshake                    Payload
//   point     point_valid / point_ready    point (point_t)
//   result    result_valid / result_ready  result (result_t)
//   cfg       cfg_write                    cfg_index, cfg_data
//
// One request is accepted per cycle while no stage stalls; the result register
// loads after the request has passed the holding register, the queue, and the
// product and row sum registers, with the clamp feeding it directly.
// The rate is set by the nine coordinate multipliers, one per matrix entry.
// Reset loads the identity rotation and a zero offset and empties the queue.
// A stalled result holds the back end stage by stage; the four-entry queue
// and holding register keep the input side taking requests meanwhile.
// ----------------------------------------------------------------------------
module quaternion_rotate_translate_points_core (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [qrtp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [qrtp_pkg::CFG_WIDTH-1:0]        cfg_data,
    input  wire logic                                  point_valid,
    output logic                                       point_ready,
    input  wire qrtp_pkg::point_t                      point,
    output logic                                       result_valid,
    input  wire logic                                  result_ready,
    output qrtp_pkg::result_t                          result
);

    logic              push_valid, push_ready;
    qrtp_pkg::point_t  push_data;
    logic              pop_valid, pop_ready;
    qrtp_pkg::point_t  pop_data;
    qrtp_pkg::coef_t   coef;

    qrtp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data),
        .coef        (coef)
    );

    qrtp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    qrtp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .coef         (coef),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
`default_nettype wire

FILE: bench/quaternion_rotate_translate_points_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_rotate_translate_points_core_tb: self-checking point transform bench
// Walks a short table of directed requests over extreme register settings,
// then streams random points in bursts under a range of random rotations and
// offsets. Every result is checked field by field against the table's value or
// a bit-exact rotation-matrix predictor, while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module quaternion_rotate_translate_points_core_tb;

    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 20;
    localparam logic [qrtp_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
    localparam qrtp_pkg::coord_t COORD_MAX =
        {1'b0, {(qrtp_pkg::COORD_WIDTH-1){1'b1}}};
    localparam qrtp_pkg::coord_t COORD_MIN =
        {1'b1, {(qrtp_pkg::COORD_WIDTH-1){1'b0}}};
    localparam qrtp_pkg::quat_t  QUAT_ONE =
        qrtp_pkg::quat_t'(1 << qrtp_pkg::QUAT_FRAC_BITS);
    localparam qrtp_pkg::quat_t  QUAT_MOST_NEG =
        {1'b1, {(qrtp_pkg::QUAT_WIDTH-1){1'b0}}};

    typedef struct packed {
        qrtp_pkg::quat_t  qw;
        qrtp_pkg::quat_t  qx;
        qrtp_pkg::quat_t  qy;
        qrtp_pkg::quat_t  qz;
        qrtp_pkg::coord_t ox;
        qrtp_pkg::coord_t oy;
        qrtp_pkg::coord_t oz;
    } pose_t;

    typedef struct packed {
        logic              typed;
        qrtp_pkg::result_t want;
    } check_tag_t;

    typedef struct packed {
        logic              change_pose;
        logic [2:0]        pose_id;
        qrtp_pkg::point_t  pt;
        logic              typed;
        qrtp_pkg::result_t want;
    } dir_row_t;

    logic                                  clk;
    logic                                  rst_n;
    logic                                  cfg_write;
    logic [qrtp_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index;
    logic [qrtp_pkg::CFG_WIDTH-1:0]        cfg_data;
    logic                                  point_valid;
    logic                                  point_ready;
    qrtp_pkg::point_t                      point;
    logic                                  result_valid;
    logic                                  result_ready;
    qrtp_pkg::result_t                     result;

    // Bench copy of the configuration registers.
    qrtp_pkg::quat_t   q_w;
    qrtp_pkg::quat_t   q_x;
    qrtp_pkg::quat_t   q_y;
    qrtp_pkg::quat_t   q_z;
    qrtp_pkg::coord_t  offs [3];

    qrtp_pkg::result_t expected_points [$];
    check_tag_t        directed_checks [$];
    dir_row_t          dir_rows [$];
    pose_t             pose_lib [8];

    int         error_count;
    int         reports_shown;
    int         results_checked;
    int         points_sent;
    int         settings_applied;
    int         cycle_count;
    int         ready_hold;
    bit         rx_calm;

    quaternion_rotate_translate_points_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .point        (point),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Round to nearest with ties toward plus infinity, dropping the
    // quaternion fraction bits.
    function automatic longint round_frac(input longint v);
        return (v + (longint'(1) <<< (qrtp_pkg::QUAT_FRAC_BITS - 1)))
               >>> qrtp_pkg::QUAT_FRAC_BITS;
    endfunction

    function automatic qrtp_pkg::coord_t clamp_coord(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return qrtp_pkg::coord_t'(v);
    endfunction

    function automatic qrtp_pkg::result_t transform_point(input qrtp_pkg::point_t p);
        longint w, x, y, z;
        longint ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
        longint m [9];
        longint c [3];
        longint acc;
        qrtp_pkg::coord_t  o [3];
        qrtp_pkg::result_t r;
        w = longint'(q_w);
        x = longint'(q_x);
        y = longint'(q_y);
        z = longint'(q_z);
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        xy = x * y; wz = w * z; xz = x * z; wy = w * y; yz = y * z; wx = w * x;
        m[0] = round_frac(ww + xx - yy - zz);
        m[1] = round_frac(2 * (xy - wz));
        m[2] = round_frac(2 * (xz + wy));
        m[3] = round_frac(2 * (xy + wz));
        m[4] = round_frac(ww - xx + yy - zz);
        m[5] = round_frac(2 * (yz - wx));
        m[6] = round_frac(2 * (xz - wy));
        m[7] = round_frac(2 * (yz + wx));
        m[8] = round_frac(ww - xx - yy + zz);
        c[0] = longint'(p.point_x);
        c[1] = longint'(p.point_y);
        c[2] = longint'(p.point_z);
        for (int row = 0; row < 3; row++)
        begin
            acc = (longint'(offs[row]) <<< qrtp_pkg::QUAT_FRAC_BITS)
                + m[3*row] * c[0] + m[3*row+1] * c[1] + m[3*row+2] * c[2];
            o[row] = clamp_coord(round_frac(acc));
        end
        r.out_x    = o[0];
        r.out_y    = o[1];
        r.out_z    = o[2];
        r.out_last = p.last_point;
        return r;
    endfunction

    function automatic qrtp_pkg::coord_t rand_coord();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return qrtp_pkg::coord_t'(int'($urandom_range(0, 8191)) - 4096);
        if (pick < 85)
            return qrtp_pkg::coord_t'($urandom);
        case ($urandom_range(0, 4))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return qrtp_pkg::coord_t'(1);
            3: return qrtp_pkg::coord_t'(-1);
            default: return '0;
        endcase
    endfunction

    function automatic qrtp_pkg::quat_t rand_quat();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return qrtp_pkg::quat_t'(int'($urandom_range(0, 32768)) - 16384);
        if (pick < 90)
            return qrtp_pkg::quat_t'($urandom);
        case ($urandom_range(0, 3))
            0: return QUAT_ONE;
            1: return -QUAT_ONE;
            2: return QUAT_MOST_NEG;
            default: return '0;
        endcase
    endfunction

    function automatic pose_t random_pose();
        pose_t ps;
        ps.qw = rand_quat();
        ps.qx = rand_quat();
        ps.qy = rand_quat();
        ps.qz = rand_quat();
        ps.ox = rand_coord();
        ps.oy = rand_coord();
        ps.oz = rand_coord();
        return ps;
    endfunction

    function automatic qrtp_pkg::point_t random_point();
        qrtp_pkg::point_t p;
        p.point_x    = rand_coord();
        p.point_y    = rand_coord();
        p.point_z    = rand_coord();
        p.last_point = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    // Quaternion registers take the low bits only; the rest of the word is noise.
    function automatic logic [qrtp_pkg::CFG_WIDTH-1:0] quat_word(input qrtp_pkg::quat_t q);
        logic [qrtp_pkg::CFG_WIDTH-1:0] word;
        word = qrtp_pkg::CFG_WIDTH'($urandom);
        word[qrtp_pkg::QUAT_WIDTH-1:0] = q;
        return word;
    endfunction

    task automatic write_reg(input logic [qrtp_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [qrtp_pkg::CFG_WIDTH-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            qrtp_pkg::REG_QUAT_W:   q_w = data[qrtp_pkg::QUAT_WIDTH-1:0];
            qrtp_pkg::REG_QUAT_X:   q_x = data[qrtp_pkg::QUAT_WIDTH-1:0];
            qrtp_pkg::REG_QUAT_Y:   q_y = data[qrtp_pkg::QUAT_WIDTH-1:0];
            qrtp_pkg::REG_QUAT_Z:   q_z = data[qrtp_pkg::QUAT_WIDTH-1:0];
            qrtp_pkg::REG_OFFSET_X: offs[0] = data[qrtp_pkg::COORD_WIDTH-1:0];
            qrtp_pkg::REG_OFFSET_Y: offs[1] = data[qrtp_pkg::COORD_WIDTH-1:0];
            qrtp_pkg::REG_OFFSET_Z: offs[2] = data[qrtp_pkg::COORD_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_pose(input pose_t ps);
        write_reg(qrtp_pkg::REG_QUAT_W, quat_word(ps.qw));
        write_reg(qrtp_pkg::REG_QUAT_X, quat_word(ps.qx));
        write_reg(qrtp_pkg::REG_QUAT_Y, quat_word(ps.qy));
        write_reg(qrtp_pkg::REG_QUAT_Z, quat_word(ps.qz));
        write_reg(qrtp_pkg::REG_OFFSET_X, ps.ox);
        write_reg(qrtp_pkg::REG_OFFSET_Y, ps.oy);
        write_reg(qrtp_pkg::REG_OFFSET_Z, ps.oz);
        // A write beyond the register list must leave the pose untouched.
        write_reg(REG_UNUSED, qrtp_pkg::CFG_WIDTH'($urandom));
        cfg_write <= 1'b0;
        settings_applied++;
    endtask

    // Holds the request until it is taken; valid stays high on return.
    task automatic send_point(input qrtp_pkg::point_t p, input logic typed,
                              input qrtp_pkg::result_t want);
        check_tag_t tag;
        tag.typed = typed;
        tag.want  = want;
        directed_checks.insert(directed_checks.size(), tag);
        point_valid <= 1'b1;
        point       <= p;
        do
            @(posedge clk);
        while (!point_ready);
        points_sent++;
    endtask

    task automatic drain();
        point_valid <= 1'b0;
        @(posedge clk);
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_row(input logic chg, input int pid,
                           input qrtp_pkg::coord_t px, input qrtp_pkg::coord_t py,
                           input qrtp_pkg::coord_t pz,
                           input logic last, input logic typed,
                           input qrtp_pkg::coord_t ex, input qrtp_pkg::coord_t ey,
                           input qrtp_pkg::coord_t ez);
        dir_row_t row;
        row.change_pose   = chg;
        row.pose_id       = 3'(pid);
        row.pt            = '{px, py, pz, last};
        row.typed         = typed;
        row.want          = '{ex, ey, ez, last};
        dir_rows.insert(dir_rows.size(), row);
    endtask

    always @(posedge clk)
    begin
        if (rx_calm)
            result_ready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            result_ready <= ($urandom_range(0, 2) != 0);
            ready_hold   <= $urandom_range(0, 5);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, expected_points.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Results are checked before new requests are queued, so a request taken
    // at this edge can never be matched against a result leaving at it.
    always @(posedge clk)
    begin : scoreboard
        qrtp_pkg::result_t want;
        check_tag_t        tag;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    error_count++;
                    if (reports_shown++ < MAX_REPORTS)
                        $display("%0t: unexpected result x=%0d y=%0d z=%0d last=%0b",
                                 $time, result.out_x, result.out_y, result.out_z,
                                 result.out_last);
                end
                else
                begin
                    want = expected_points.pop_front();
                    results_checked++;
                    if (result.out_x !== want.out_x || result.out_y !== want.out_y ||
                        result.out_z !== want.out_z || result.out_last !== want.out_last)
                    begin
                        error_count++;
                        if (reports_shown++ < MAX_REPORTS)
                            $display({"%0t: mismatch expected x=%0d y=%0d z=%0d last=%0b,",
                                      " got x=%0d y=%0d z=%0d last=%0b"},
                                     $time, want.out_x, want.out_y, want.out_z,
                                     want.out_last, result.out_x, result.out_y,
                                     result.out_z, result.out_last);
                    end
                end
            end
            if (point_valid && point_ready)
            begin
                tag = (directed_checks.size() != 0) ? directed_checks.pop_front() : '0;
                expected_points.insert(expected_points.size(),
                                       tag.typed ? tag.want : transform_point(point));
            end
        end
    end

    initial
    begin : stimulus
        int burst;
        int gap;
        int sent;
        bit tx_calm;
        clk          = 1'b0;
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        point_valid  = 1'b0;
        point        = '0;
        result_ready = 1'b0;
        ready_hold   = 0;
        rx_calm      = 1'b0;
        cycle_count  = 0;
        q_w = QUAT_ONE;
        q_x = '0;
        q_y = '0;
        q_z = '0;
        offs[0] = '0;
        offs[1] = '0;
        offs[2] = '0;

        pose_lib[0] = '{QUAT_ONE, 16'sd0, 16'sd0, 16'sd0, 24'sd0, 24'sd0, 24'sd0};
        pose_lib[1] = '{QUAT_ONE, 16'sd0, 16'sd0, 16'sd0, COORD_MAX, COORD_MIN, 24'sd0};
        // Half turn about z: x and y change sign.
        pose_lib[2] = '{16'sd0, 16'sd0, 16'sd0, QUAT_ONE, 24'sd0, 24'sd0, 24'sd0};
        pose_lib[3] = '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 24'sd256, -24'sd256, 24'sd1};
        // Not normalized: the matrix scales as well as rotates.
        pose_lib[4] = '{QUAT_ONE, QUAT_ONE, QUAT_ONE, QUAT_ONE,
                        COORD_MAX, COORD_MAX, COORD_MAX};
        pose_lib[5] = '{QUAT_MOST_NEG, QUAT_MOST_NEG, QUAT_MOST_NEG, QUAT_MOST_NEG,
                        COORD_MIN, COORD_MIN, COORD_MIN};
        pose_lib[6] = '{-QUAT_ONE, -QUAT_ONE, -QUAT_ONE, -QUAT_ONE,
                        24'sd0, COORD_MAX, COORD_MIN};
        pose_lib[7] = '{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192,
                        24'sd1000, -24'sd1000, 24'sd7};

        // Identity after reset passes points through unchanged.
        add_row(1'b0, 0, 24'sd0, 24'sd0, 24'sd0, 1'b0, 1'b1, 24'sd0, 24'sd0, 24'sd0);
        add_row(1'b0, 0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1,
                COORD_MAX, COORD_MAX, COORD_MAX);
        add_row(1'b0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 1'b1,
                COORD_MIN, COORD_MIN, COORD_MIN);
        add_row(1'b0, 0, 24'sd1, -24'sd1, 24'sd256, 1'b1, 1'b1, 24'sd1, -24'sd1, 24'sd256);
        add_row(1'b0, 0, 24'h555555, 24'shAAAAAA, -24'sd3, 1'b0, 1'b1,
                24'h555555, 24'shAAAAAA, -24'sd3);
        // Offsets at the extremes: saturation both ways, and exact cancellation.
        add_row(1'b1, 1, COORD_MAX, COORD_MIN, 24'sd5, 1'b0, 1'b1,
                COORD_MAX, COORD_MIN, 24'sd5);
        add_row(1'b0, 1, COORD_MIN, COORD_MAX, -24'sd5, 1'b1, 1'b1,
                -24'sd1, -24'sd1, -24'sd5);
        // Negating the most negative coordinate saturates high.
        add_row(1'b1, 2, COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1,
                COORD_MAX, -24'sd8388607, COORD_MIN);
        add_row(1'b0, 2, 24'sd300, -24'sd700, 24'sd9, 1'b0, 1'b1,
                -24'sd300, 24'sd700, 24'sd9);
        for (int pid = 3; pid < 8; pid++)
        begin
            add_row(1'b1, pid, COORD_MAX, COORD_MIN, 24'sd1234, 1'b0, 1'b0,
                    24'sd0, 24'sd0, 24'sd0);
            add_row(1'b0, pid, -24'sd4096, 24'sd77, COORD_MAX, 1'b1, 1'b0,
                    24'sd0, 24'sd0, 24'sd0);
            add_row(1'b0, pid, 24'sd3, 24'sd0, -24'sd1, 1'b0, 1'b0,
                    24'sd0, 24'sd0, 24'sd0);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].change_pose)
            begin
                drain();
                apply_pose(pose_lib[dir_rows[i].pose_id]);
            end
            send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            if (ph % 3 == 0)
                apply_pose(pose_lib[$urandom_range(0, 7)]);
            else
                apply_pose(random_pose());
            rx_calm = (ph % 4 == 1);
            tx_calm = (ph % 4 == 2);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 16);
                for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++)
                begin
                    send_point(random_point(), 1'b0, '0);
                    sent++;
                end
                gap = tx_calm ? 0 : $urandom_range(0, 6);
                if (gap != 0)
                begin
                    point_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        rx_calm = 1'b0;
        drain();

        if (expected_points.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_points.size());
        end
        $display("Sent %0d points (%0d from the directed table) under %0d register settings.",
                 points_sent, dir_rows.size(), settings_applied);
        $display("Checked %0d results, %0d mismatches.", results_checked, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/qrtp_pkg.sv
hdl/qrtp_front.sv
hdl/qrtp_queue.sv
hdl/qrtp_back.sv
hdl/quaternion_rotate_translate_points_core.sv
bench/quaternion_rotate_translate_points_core_tb.sv
